/* src/plip_pkg.sv */
// shared types and constants for the parallel-port nibble link engine
`timescale 1ns / 1ps

package plip_pkg;

	localparam int FRAME_BYTES = 2048;
	localparam int CNT_W = $clog2(FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_BYTES);

	localparam logic [23:0] TIMEOUT_RESET = 24'd1000000;

	localparam logic [2:0] REQ_DATA = 3'd0;
	localparam logic [2:0] REQ_CTRL = 3'd1;
	localparam logic [2:0] REQ_STATUS = 3'd2;
	localparam logic [2:0] REQ_NET = 3'd3;
	localparam logic [2:0] REQ_TICK = 3'd4;

	localparam logic [7:0] ST_IDLE = 8'h80;
	localparam logic [7:0] ST_RX_START = 8'hc7;
	localparam logic [7:0] ST_TX_START = 8'h08;
	localparam logic [7:0] ST_BUSY = 8'h80;
	localparam logic [7:0] ST_ACK = 8'h40;
	localparam logic [7:0] ST_TX_ACK_MASK = 8'h88;

	typedef enum logic [4:0] {
		PH_START,
		PH_TX_L0, PH_TX_L1, PH_TX_L2, PH_TX_L3,
		PH_TX_D0, PH_TX_D1, PH_TX_C0, PH_TX_C1,
		PH_RX_L0, PH_RX_L1, PH_RX_L2, PH_RX_L3,
		PH_RX_D0, PH_RX_D1, PH_RX_C0, PH_RX_C1,
		PH_END
	} phase_t;

	typedef struct packed {
		logic [7:0] port_status;
		logic       irq_pulse;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_end;
		logic       tx_good;
		logic       rx_declined;
	} result_t;

	// nibble placed on status bits 6:3
	function automatic logic [7:0] nib_status(input logic [3:0] n, input logic busy);
		return {busy, n, 3'b000};
	endfunction

endpackage

/* src/plip_nibble_link_engine.sv */
// parallel-port nibble link engine: handshake machine, receive buffer and result skid
`timescale 1ns / 1ps

//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | req_type, data_value, rx_last
//  out      | out_valid / out_stall| port_status, irq_pulse, tx_*, rx_declined
//  cfg      | cfg_valid / cfg_ready| cfg_data (timeout_ticks)
//
// one word per cycle while in_stall is low: each word updates the state in its
// accept cycle and its result is registered in the output register or the skid
// the receive buffer read is prefetched from the next buffer index (recv_idx_d)
// a two-deep output register/skid stage takes in one more word while output is stalled
// in_stall rises only when the skid holds a word
// arst_n resets control state; the receive buffer holds no reset

module plip_nibble_link_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  data_value,
	input  logic        rx_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  port_status,
	output logic        irq_pulse,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        tx_end,
	output logic        tx_good,
	output logic        rx_declined,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	localparam int CW = plip_pkg::CNT_W;
	localparam int AW = plip_pkg::ADDR_W;

	plip_pkg::phase_t phase_q, phase_d;
	logic [7:0]  status_q, status_d;
	logic [15:0] send_len_q, send_len_d;
	logic [15:0] send_idx_q, send_idx_d;
	logic [7:0]  send_sum_q, send_sum_d;
	logic [7:0]  sum_rx_q, sum_rx_d;
	logic [3:0]  send_lo_q, send_lo_d;
	logic [CW-1:0] recv_len_q, recv_len_d;
	logic [CW-1:0] recv_idx_q, recv_idx_d;
	logic [7:0]  recv_sum_q, recv_sum_d;
	logic [CW-1:0] load_cnt_q, load_cnt_d;
	logic        dropping_q, dropping_d;
	logic        armed_q, armed_d;
	logic [23:0] left_q, left_d;
	logic        pending_q, pending_d;
	logic [23:0] timeout_q;

	logic [7:0]  mem [plip_pkg::FRAME_BYTES];
	logic [7:0]  rd_q;
	logic        mem_we;

	plip_pkg::result_t res, out_q, skid_q;
	logic        out_valid_q, skid_valid_q;

	logic        accept, out_take;
	logic        d4;
	logic [7:0]  v;
	logic        load_drop, load_room;
	logic [CW-1:0] load_next;
	logic [23:0] left_dec;
	logic        tmo_fire;
	logic [15:0] len16;
	logic [CW-1:0] idx_inc;

	assign accept = in_valid & ~in_stall;
	assign in_stall = skid_valid_q;
	assign out_take = out_valid_q & ~out_stall;
	assign cfg_ready = 1'b1;

	assign v = data_value;
	assign d4 = data_value[4];
	assign load_drop = dropping_q | ((load_cnt_q == '0) & (recv_len_q != '0));
	assign load_room = load_cnt_q < CW'(plip_pkg::FRAME_BYTES);
	assign load_next = load_room ? load_cnt_q + CW'(1) : load_cnt_q;
	assign left_dec = (left_q != '0) ? left_q - 24'd1 : '0;
	assign tmo_fire = armed_q & (left_dec == '0);
	assign len16 = 16'(recv_len_q);
	assign idx_inc = recv_idx_q + CW'(1);
	assign mem_we = accept & (req_type == plip_pkg::REQ_NET) & ~load_drop & load_room;

	// next state
	always_comb begin
		phase_d = phase_q;
		status_d = status_q;
		send_len_d = send_len_q;
		send_idx_d = send_idx_q;
		send_sum_d = send_sum_q;
		sum_rx_d = sum_rx_q;
		send_lo_d = send_lo_q;
		recv_len_d = recv_len_q;
		recv_idx_d = recv_idx_q;
		recv_sum_d = recv_sum_q;
		load_cnt_d = load_cnt_q;
		dropping_d = dropping_q;
		armed_d = armed_q;
		left_d = left_q;
		pending_d = pending_q;
		if (accept) begin
			case (req_type)
				plip_pkg::REQ_DATA: begin
					case (phase_q)
						plip_pkg::PH_START: begin
							if (v[3]) begin
								phase_d = plip_pkg::PH_TX_L0;
								status_d = plip_pkg::ST_TX_START;
							end
						end
						plip_pkg::PH_TX_L0: begin
							if (d4) begin
								send_len_d = {12'h000, v[3:0]};
								phase_d = plip_pkg::PH_TX_L1;
								status_d = status_q & ~plip_pkg::ST_TX_ACK_MASK;
							end
						end
						plip_pkg::PH_TX_L1: begin
							if (!d4) begin
								send_len_d = send_len_q | {8'h00, v[3:0], 4'h0};
								phase_d = plip_pkg::PH_TX_L2;
								status_d = status_q | plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_TX_L2: begin
							if (d4) begin
								send_len_d = send_len_q | {4'h0, v[3:0], 8'h00};
								phase_d = plip_pkg::PH_TX_L3;
								status_d = status_q & ~plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_TX_L3: begin
							if (!d4) begin
								send_len_d = send_len_q | {v[3:0], 12'h000};
								send_idx_d = '0;
								send_sum_d = '0;
								phase_d = plip_pkg::PH_TX_D0;
								status_d = status_q | plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_TX_D0: begin
							if (d4) begin
								send_lo_d = v[3:0];
								phase_d = plip_pkg::PH_TX_D1;
								status_d = status_q & ~plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_TX_D1: begin
							if (!d4) begin
								// bytes past the frame size are not kept or summed
								if (send_idx_q < 16'(plip_pkg::FRAME_BYTES))
									send_sum_d = send_sum_q + {v[3:0], send_lo_q};
								send_idx_d = send_idx_q + 16'd1;
								phase_d = (send_idx_d < send_len_q) ? plip_pkg::PH_TX_D0
								                                    : plip_pkg::PH_TX_C0;
								status_d = status_q | plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_TX_C0: begin
							if (d4) begin
								sum_rx_d = {4'h0, v[3:0]};
								phase_d = plip_pkg::PH_TX_C1;
								status_d = status_q & ~plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_TX_C1: begin
							if (!d4) begin
								sum_rx_d = sum_rx_q | {v[3:0], 4'h0};
								send_len_d = '0;
								phase_d = plip_pkg::PH_END;
								status_d = status_q | plip_pkg::ST_BUSY;
							end
						end
						plip_pkg::PH_RX_L0: begin
							if (v[0]) begin
								status_d = plip_pkg::nib_status(len16[3:0], 1'b0);
								phase_d = plip_pkg::PH_RX_L1;
							end else if (v[3]) begin
								phase_d = plip_pkg::PH_TX_L0;
								status_d = plip_pkg::ST_TX_START;
							end
						end
						plip_pkg::PH_RX_L1: begin
							if (d4) begin
								status_d = plip_pkg::nib_status(len16[7:4], 1'b1);
								phase_d = plip_pkg::PH_RX_L2;
							end
						end
						plip_pkg::PH_RX_L2: begin
							if (!d4) begin
								status_d = plip_pkg::nib_status(len16[11:8], 1'b0);
								phase_d = plip_pkg::PH_RX_L3;
							end
						end
						plip_pkg::PH_RX_L3: begin
							if (d4) begin
								status_d = plip_pkg::nib_status(len16[15:12], 1'b1);
								recv_idx_d = '0;
								recv_sum_d = '0;
								phase_d = plip_pkg::PH_RX_D0;
							end
						end
						plip_pkg::PH_RX_D0: begin
							if (!d4) begin
								status_d = plip_pkg::nib_status(rd_q[3:0], 1'b0);
								phase_d = plip_pkg::PH_RX_D1;
							end
						end
						plip_pkg::PH_RX_D1: begin
							if (d4) begin
								status_d = plip_pkg::nib_status(rd_q[7:4], 1'b1);
								recv_sum_d = recv_sum_q + rd_q;
								recv_idx_d = idx_inc;
								phase_d = (idx_inc < recv_len_q) ? plip_pkg::PH_RX_D0
								                                 : plip_pkg::PH_RX_C0;
							end
						end
						plip_pkg::PH_RX_C0: begin
							if (!d4) begin
								status_d = plip_pkg::nib_status(recv_sum_q[3:0], 1'b0);
								phase_d = plip_pkg::PH_RX_C1;
							end
						end
						plip_pkg::PH_RX_C1: begin
							if (d4) begin
								status_d = plip_pkg::nib_status(recv_sum_q[7:4], 1'b1);
								recv_len_d = '0;
								phase_d = plip_pkg::PH_END;
							end
						end
						plip_pkg::PH_END: begin
							if (v == 8'h00) begin
								status_d = plip_pkg::ST_IDLE;
								phase_d = plip_pkg::PH_START;
								pending_d = 1'b1;
							end
						end
						default: begin
						end
					endcase
					// any accepted handshake step rearms the timeout; a request in PH_END disarms it
					if (phase_q == plip_pkg::PH_END) begin
						armed_d = 1'b0;
					end else if (phase_d != phase_q || status_d != status_q ||
					             (phase_q == plip_pkg::PH_TX_D1 && !d4) ||
					             (phase_q == plip_pkg::PH_TX_D0 && d4) ||
					             (phase_q == plip_pkg::PH_TX_C0 && d4)) begin
						armed_d = 1'b1;
						left_d = timeout_q;
					end
				end
				plip_pkg::REQ_CTRL: begin
					if (v[4])
						pending_d = 1'b1;
				end
				plip_pkg::REQ_NET: begin
					if (load_drop) begin
						dropping_d = ~rx_last;
					end else begin
						load_cnt_d = load_next;
						if (rx_last) begin
							recv_len_d = load_next;
							load_cnt_d = '0;
							if (load_next != '0 && phase_q == plip_pkg::PH_START) begin
								status_d = plip_pkg::ST_RX_START;
								phase_d = plip_pkg::PH_RX_L0;
								armed_d = 1'b1;
								left_d = timeout_q;
							end
						end
					end
				end
				plip_pkg::REQ_TICK: begin
					if (armed_q) begin
						left_d = left_dec;
						if (tmo_fire) begin
							phase_d = plip_pkg::PH_START;
							status_d = plip_pkg::ST_IDLE;
							armed_d = 1'b0;
						end
					end
					if (pending_q) begin
						pending_d = 1'b0;
						if (recv_len_q != '0 && phase_d == plip_pkg::PH_START) begin
							status_d = plip_pkg::ST_RX_START;
							phase_d = plip_pkg::PH_RX_L0;
							armed_d = 1'b1;
							left_d = timeout_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res = '0;
		res.port_status = status_d;
		case (req_type)
			plip_pkg::REQ_DATA: begin
				if (phase_q == plip_pkg::PH_TX_D1 && !d4 &&
				    send_idx_q < 16'(plip_pkg::FRAME_BYTES)) begin
					res.tx_valid = 1'b1;
					res.tx_byte = {v[3:0], send_lo_q};
				end
				if (phase_q == plip_pkg::PH_TX_C1 && !d4) begin
					res.tx_end = 1'b1;
					res.tx_good = send_sum_q == (sum_rx_q | {v[3:0], 4'h0});
				end
			end
			plip_pkg::REQ_NET: begin
				res.rx_declined = load_drop;
				if (!load_drop && rx_last && load_next != '0)
					res.irq_pulse = (phase_q == plip_pkg::PH_START) | status_q[6];
			end
			plip_pkg::REQ_TICK: begin
				// a busy link re-raises the interrupt when the ack bit is set
				if (pending_q && recv_len_q != '0)
					res.irq_pulse = tmo_fire | (phase_q == plip_pkg::PH_START) |
					                status_q[6];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= plip_pkg::PH_START;
			status_q <= plip_pkg::ST_IDLE;
			send_len_q <= '0;
			send_idx_q <= '0;
			send_sum_q <= '0;
			sum_rx_q <= '0;
			send_lo_q <= '0;
			recv_len_q <= '0;
			recv_idx_q <= '0;
			recv_sum_q <= '0;
			load_cnt_q <= '0;
			dropping_q <= 1'b0;
			armed_q <= 1'b0;
			left_q <= '0;
			pending_q <= 1'b0;
			timeout_q <= plip_pkg::TIMEOUT_RESET;
		end else begin
			phase_q <= phase_d;
			status_q <= status_d;
			send_len_q <= send_len_d;
			send_idx_q <= send_idx_d;
			send_sum_q <= send_sum_d;
			sum_rx_q <= sum_rx_d;
			send_lo_q <= send_lo_d;
			recv_len_q <= recv_len_d;
			recv_idx_q <= recv_idx_d;
			recv_sum_q <= recv_sum_d;
			load_cnt_q <= load_cnt_d;
			dropping_q <= dropping_d;
			armed_q <= armed_d;
			left_q <= left_d;
			pending_q <= pending_d;
			if (cfg_valid && cfg_ready)
				timeout_q <= cfg_data;
		end
	end

	// receive buffer: rd_q always holds the entry at the current buffer index
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[load_cnt_q[AW-1:0]] <= v;
		if (mem_we && load_cnt_q[AW-1:0] == recv_idx_d[AW-1:0])
			rd_q <= v;
		else
			rd_q <= mem[recv_idx_d[AW-1:0]];
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q || out_take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_take) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || out_take)
				out_q <= res;
			else
				skid_q <= res;
		end else if (out_take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign port_status = out_q.port_status;
	assign irq_pulse = out_q.irq_pulse;
	assign tx_valid = out_q.tx_valid;
	assign tx_byte = out_q.tx_byte;
	assign tx_end = out_q.tx_end;
	assign tx_good = out_q.tx_good;
	assign rx_declined = out_q.rx_declined;

endmodule
